// ----- src/kinl_pkg.sv -----
package kinl_pkg;

   // Token kinds as they leave on rsp_tuser.
   typedef enum logic [3:0] {
      KIND_EXIT    = 4'd0,
      KIND_LET     = 4'd1,
      KIND_IDENT   = 4'd2,
      KIND_INT_LIT = 4'd3,
      KIND_OPEN    = 4'd4,
      KIND_CLOSE   = 4'd5,
      KIND_EQUALS  = 4'd6,
      KIND_SEMI    = 4'd7,
      KIND_ERROR   = 4'd8,
      KIND_END     = 4'd9
   } kinl_kind_type;

   // Class of the run being collected.
   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_IDENT = 2'd1,
      CLASS_INT   = 2'd2
   } kinl_class_type;

   localparam int TOKEN_TEXT_W = 64;
   localparam int LENGTH_W     = 8;
   localparam int ERR_POS_W    = 24;
   localparam int CHAR_W       = 8;

   localparam logic [CHAR_W-1:0] CHAR_OPEN   = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE  = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_EQUALS = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_SEMI   = 8'h3B;

   // Keyword text, first character in the low byte.
   localparam logic [TOKEN_TEXT_W-1:0] KW_EXIT_TEXT = 64'h0000_0000_7469_7865;
   localparam logic [TOKEN_TEXT_W-1:0] KW_LET_TEXT  = 64'h0000_0000_0074_656C;
   localparam logic [LENGTH_W-1:0]     KW_EXIT_LEN  = 8'd4;
   localparam logic [LENGTH_W-1:0]     KW_LET_LEN   = 8'd3;
   localparam logic [LENGTH_W-1:0]     LENGTH_MAX   = 8'd255;

   // Result queue: room for two pushes per cycle while one waits.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ERR_POS_W-1:0]    error_position;
      logic                    text_truncated;
      logic [LENGTH_W-1:0]     text_length;
      logic [TOKEN_TEXT_W-1:0] token_text;
      kinl_kind_type           token_kind;
      logic                    last_of_run;
   } kinl_token_type;

   // Up to two tokens from one input transfer; first goes out first.
   typedef struct packed {
      logic [1:0]     count;
      kinl_token_type first;
      kinl_token_type second;
   } kinl_push_type;

endpackage

// ----- src/kinl_token_queue.sv -----
module kinl_token_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  kinl_pkg::kinl_push_type push,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output kinl_pkg::kinl_token_type out_token
);
   import kinl_pkg::*;

   kinl_token_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_next;
   logic              pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_token = entry_ff[rd_ptr_ff];
   // two free slots needed, since one transfer may yield two tokens
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push.count != 2'd0 && wr_ptr_ff == QPTR_W'(i)) begin
            entry_ff[i] <= push.first;
         end else if (push.count == 2'd2 && wr_next == QPTR_W'(i)) begin
            entry_ff[i] <= push.second;
         end
      end
   end

endmodule

// ----- src/keyword_ident_number_lexer.sv -----
// Byte-serial lexer for keywords (exit, let), identifiers, integer literals
// and the punctuation ( ) = ;. Whitespace only separates tokens.
//
// req channel: one source byte per transfer on req_tdata; req_tlast marks
// end of input, which flushes the pending run, emits an end token and
// returns the lexer to its reset state (the byte in that transfer is unused).
// An unknown byte yields an error token with its byte index; later bytes
// give no tokens until end of input.
//
// rsp channel: one token per transfer. A req transfer yields zero, one or
// two tokens; rsp_tlast marks the final token of a req transfer.
//
// Throughput: one req transfer per cycle while the four-entry result queue has
// room; the queue takes up to two tokens per cycle and sends one. Tokens are
// registered in the queue before they appear on rsp.
// When rsp stalls the queue fills and req_tready drops once fewer than two
// slots remain; it rises again as soon as two are free.
// Reset (synchronous) clears the run state, the byte index and the queue.
module keyword_ident_number_lexer #(
   parameter int TEXT_BYTES    = 8,
   parameter int POSITION_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] char_code
   input  logic         req_tlast,   // end_of_input
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [63:0] token_text, [71:64] text_length,
                                     // [72] text_truncated, [96:73] error_position,
                                     // [103:97] zero
   output logic [3:0]   rsp_tuser,   // [3:0] token_kind
   output logic         rsp_tlast    // last_of_run
);
   import kinl_pkg::*;

   localparam int RUN_W = TEXT_BYTES * CHAR_W;

   // run state
   kinl_class_type           run_class_ff, run_class_in;
   logic [RUN_W-1:0]         run_text_ff, run_text_in;
   logic [LENGTH_W-1:0]      run_length_ff, run_length_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic                     halted_ff, halted_in;

   logic                     accept;
   logic [CHAR_W-1:0]        ch;
   logic                     is_letter, is_digit, is_space;
   logic                     extend;
   logic                     flush_valid;
   logic                     single_valid;
   kinl_token_type           flush_tok, single_tok;
   kinl_push_type            push;
   kinl_token_type           out_tok;
   logic [RUN_W-1:0]         appended_text;
   logic [31:0]              position_wide;
   logic [TOKEN_TEXT_W-1:0]  run_text_wide;

   assign accept        = req_tvalid && req_tready;
   assign ch            = req_tdata;
   assign position_wide = 32'(position_ff);
   assign run_text_wide = TOKEN_TEXT_W'(run_text_ff);

   always_comb begin
      is_letter = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
      is_digit  = (ch inside {[8'h30:8'h39]});
      is_space  = (ch inside {[8'h09:8'h0D], 8'h20});
      extend    = (run_class_ff == CLASS_IDENT && (is_letter || is_digit)) ||
                  (run_class_ff == CLASS_INT && is_digit);
   end

   // run text with the current byte placed at the next free slot
   always_comb begin
      appended_text = run_text_ff;
      for (int i = 0; i < TEXT_BYTES; i++) begin
         if (run_length_ff == LENGTH_W'(i)) begin
            appended_text[i*CHAR_W +: CHAR_W] = ch;
         end
      end
   end

   // token for the pending run
   always_comb begin
      flush_tok                = '0;
      flush_tok.token_text     = run_text_wide;
      flush_tok.text_length    = run_length_ff;
      flush_tok.text_truncated = (run_length_ff > LENGTH_W'(TEXT_BYTES));
      if (run_class_ff == CLASS_INT) begin
         flush_tok.token_kind = KIND_INT_LIT;
      end else if (run_length_ff == KW_EXIT_LEN && run_text_wide == KW_EXIT_TEXT) begin
         flush_tok.token_kind = KIND_EXIT;
      end else if (run_length_ff == KW_LET_LEN && run_text_wide == KW_LET_TEXT) begin
         flush_tok.token_kind = KIND_LET;
      end else begin
         flush_tok.token_kind = KIND_IDENT;
      end
   end

   // next state and the tokens of this transfer
   always_comb begin
      run_class_in  = run_class_ff;
      run_text_in   = run_text_ff;
      run_length_in = run_length_ff;
      position_in   = position_ff;
      halted_in     = halted_ff;
      flush_valid   = 1'b0;
      single_valid  = 1'b0;
      single_tok    = '0;

      if (accept) begin
         if (req_tlast) begin
            flush_valid           = !halted_ff && run_class_ff != CLASS_NONE;
            single_valid          = 1'b1;
            single_tok.token_kind = KIND_END;
            run_class_in          = CLASS_NONE;
            run_text_in           = '0;
            run_length_in         = '0;
            position_in           = '0;
            halted_in             = 1'b0;
         end else begin
            position_in = position_ff + POSITION_BITS'(1);
            if (!halted_ff) begin
               if (extend) begin
                  run_text_in   = appended_text;
                  run_length_in = (run_length_ff == LENGTH_MAX) ? run_length_ff
                                                                : run_length_ff + 8'd1;
               end else begin
                  flush_valid              = (run_class_ff != CLASS_NONE);
                  run_class_in             = CLASS_NONE;
                  run_text_in              = '0;
                  run_length_in            = '0;
                  single_tok.token_text    = TOKEN_TEXT_W'(ch);
                  single_tok.text_length   = 8'd1;
                  if (is_letter || is_digit) begin
                     run_class_in          = is_letter ? CLASS_IDENT : CLASS_INT;
                     run_text_in           = RUN_W'(ch);
                     run_length_in         = 8'd1;
                  end else if (is_space) begin
                     single_valid          = 1'b0;
                  end else begin
                     single_valid          = 1'b1;
                     case (ch)
                        CHAR_OPEN:   single_tok.token_kind = KIND_OPEN;
                        CHAR_CLOSE:  single_tok.token_kind = KIND_CLOSE;
                        CHAR_EQUALS: single_tok.token_kind = KIND_EQUALS;
                        CHAR_SEMI:   single_tok.token_kind = KIND_SEMI;
                        default: begin
                           single_tok.token_kind     = KIND_ERROR;
                           single_tok.error_position = position_wide[ERR_POS_W-1:0];
                           halted_in                 = 1'b1;
                        end
                     endcase
                  end
               end
            end
         end
      end
   end

   // order the tokens: pending run first, then the single-byte token
   always_comb begin
      push        = '0;
      push.first  = flush_tok;
      push.second = single_tok;
      if (flush_valid && single_valid) begin
         push.count              = 2'd2;
         push.second.last_of_run = 1'b1;
      end else if (flush_valid) begin
         push.count             = 2'd1;
         push.first.last_of_run = 1'b1;
      end else if (single_valid) begin
         push.count             = 2'd1;
         push.first             = single_tok;
         push.first.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_class_ff  <= CLASS_NONE;
         run_text_ff   <= '0;
         run_length_ff <= '0;
         position_ff   <= '0;
         halted_ff     <= 1'b0;
      end else begin
         run_class_ff  <= run_class_in;
         run_text_ff   <= run_text_in;
         run_length_ff <= run_length_in;
         position_ff   <= position_in;
         halted_ff     <= halted_in;
      end
   end

   kinl_token_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_token (out_tok)
   );

   assign rsp_tdata = {7'd0, out_tok.error_position, out_tok.text_truncated,
                       out_tok.text_length, out_tok.token_text};
   assign rsp_tuser = out_tok.token_kind;
   assign rsp_tlast = out_tok.last_of_run;

   // no run is open while halted on an error
   a_halt_no_run: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> run_class_ff == CLASS_NONE)
      else $error("run open while halted");

   // closed run leaves no text or length behind
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      run_class_ff == CLASS_NONE |-> (run_length_ff == '0 && run_text_ff == '0))
      else $error("stale run state");

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("token after reset");

   // truncation only flagged on runs longer than the stored text
   a_trunc_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_tok.text_truncated) |->
         out_tok.text_length > LENGTH_W'(TEXT_BYTES))
      else $error("bad truncation flag");

endmodule
